### hdl/oled_text_glyph_writer_defines.svh
// assertion macros for the oled text glyph writer
// no dependencies; modules that carry assertions include this file
`ifndef OLED_TEXT_GLYPH_WRITER_DEFINES_SVH
`define OLED_TEXT_GLYPH_WRITER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define OTGW_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("otgw assertion failed");

// next-cycle implication, checked outside reset
`define OTGW_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("otgw assertion failed");

`endif

### hdl/otgw_pkg.sv
// types, constants and the 6x8 font table for the oled text glyph writer
// no dependencies
`default_nettype none

package otgw_pkg;

  localparam int unsigned FontFirst = 32;
  localparam int unsigned FontCount = 92;
  localparam int unsigned JobDepth  = 2;
  localparam int unsigned JobPtrW   = $clog2(JobDepth);
  localparam int unsigned JobCntW   = $clog2(JobDepth + 1);

  localparam logic [6:0] WrapLimitReset = 7'd126;
  localparam logic [7:0] GlyphAdvance   = 8'd6;
  localparam logic [4:0] PageCmdHigh    = 5'b10110;
  localparam logic [3:0] ColHiCmdHigh   = 4'h1;
  localparam logic [3:0] ColLoCmdHigh   = 4'h0;

  typedef struct packed {
    logic       new_text;
    logic [6:0] start_column;
    logic [2:0] start_page;
    logic [7:0] char_code;
  } otgw_in_t;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       is_data;
    logic       last;
    logic       bad_char;
  } otgw_out_t;

  typedef struct packed {
    logic       bad;
    logic [6:0] glyph;
    logic [2:0] page;
    logic [6:0] column;
  } otgw_job_t;

  typedef enum logic [3:0] {
    BeatPage,
    BeatColHi,
    BeatColLo,
    BeatGlyph0,
    BeatGlyph1,
    BeatGlyph2,
    BeatGlyph3,
    BeatGlyph4,
    BeatGlyph5
  } otgw_beat_e;

  function automatic logic [47:0] font_row(input logic [6:0] idx);
    logic [47:0] row;
    unique case (idx)
      7'd0:  row = 48'h000000000000;
      7'd1:  row = 48'h0000002f0000;
      7'd2:  row = 48'h000007000700;
      7'd3:  row = 48'h00147f147f14;
      7'd4:  row = 48'h00242a7f2a12;
      7'd5:  row = 48'h006264081323;
      7'd6:  row = 48'h003649552250;
      7'd7:  row = 48'h000005030000;
      7'd8:  row = 48'h00001c224100;
      7'd9:  row = 48'h000041221c00;
      7'd10: row = 48'h0014083e0814;
      7'd11: row = 48'h0008083e0808;
      7'd12: row = 48'h000000a06000;
      7'd13: row = 48'h000808080808;
      7'd14: row = 48'h000060600000;
      7'd15: row = 48'h002010080402;
      7'd16: row = 48'h003e5149453e;
      7'd17: row = 48'h0000427f4000;
      7'd18: row = 48'h004261514946;
      7'd19: row = 48'h002141454b31;
      7'd20: row = 48'h001814127f10;
      7'd21: row = 48'h002745454539;
      7'd22: row = 48'h003c4a494930;
      7'd23: row = 48'h000171090503;
      7'd24: row = 48'h003649494936;
      7'd25: row = 48'h00064949291e;
      7'd26: row = 48'h000036360000;
      7'd27: row = 48'h000056360000;
      7'd28: row = 48'h000814224100;
      7'd29: row = 48'h001414141414;
      7'd30: row = 48'h000041221408;
      7'd31: row = 48'h000201510906;
      7'd32: row = 48'h00324959513e;
      7'd33: row = 48'h007c1211127c;
      7'd34: row = 48'h007f49494936;
      7'd35: row = 48'h003e41414122;
      7'd36: row = 48'h007f4141221c;
      7'd37: row = 48'h007f49494941;
      7'd38: row = 48'h007f09090901;
      7'd39: row = 48'h003e4149497a;
      7'd40: row = 48'h007f0808087f;
      7'd41: row = 48'h0000417f4100;
      7'd42: row = 48'h002040413f01;
      7'd43: row = 48'h007f08142241;
      7'd44: row = 48'h007f40404040;
      7'd45: row = 48'h007f020c027f;
      7'd46: row = 48'h007f0408107f;
      7'd47: row = 48'h003e4141413e;
      7'd48: row = 48'h007f09090906;
      7'd49: row = 48'h003e4151215e;
      7'd50: row = 48'h007f09192946;
      7'd51: row = 48'h004649494931;
      7'd52: row = 48'h0001017f0101;
      7'd53: row = 48'h003f4040403f;
      7'd54: row = 48'h001f2040201f;
      7'd55: row = 48'h003f4038403f;
      7'd56: row = 48'h006314081463;
      7'd57: row = 48'h000708700807;
      7'd58: row = 48'h006151494543;
      7'd59: row = 48'h00007f414100;
      7'd60: row = 48'h000204081020;
      7'd61: row = 48'h000041417f00;
      7'd62: row = 48'h000402010204;
      7'd63: row = 48'h004040404040;
      7'd64: row = 48'h000001020400;
      7'd65: row = 48'h002054545478;
      7'd66: row = 48'h007f48444438;
      7'd67: row = 48'h003844444420;
      7'd68: row = 48'h00384444487f;
      7'd69: row = 48'h003854545418;
      7'd70: row = 48'h00087e090102;
      7'd71: row = 48'h0018a4a4a47c;
      7'd72: row = 48'h007f08040478;
      7'd73: row = 48'h0000447d4000;
      7'd74: row = 48'h004080847d00;
      7'd75: row = 48'h007f10284400;
      7'd76: row = 48'h0000417f4000;
      7'd77: row = 48'h007c04180478;
      7'd78: row = 48'h007c08040478;
      7'd79: row = 48'h003844444438;
      7'd80: row = 48'h00fc24242418;
      7'd81: row = 48'h0018242418fc;
      7'd82: row = 48'h007c08040408;
      7'd83: row = 48'h004854545420;
      7'd84: row = 48'h00043f444020;
      7'd85: row = 48'h003c4040207c;
      7'd86: row = 48'h001c2040201c;
      7'd87: row = 48'h003c4030403c;
      7'd88: row = 48'h004428102844;
      7'd89: row = 48'h001ca0a0a07c;
      7'd90: row = 48'h004464544c44;
      7'd91: row = 48'h141414141414;
      default: row = 48'h000000000000;
    endcase
    return row;
  endfunction

endpackage

`default_nettype wire

### hdl/otgw_front.sv
// front end: takes characters, keeps the cursor and the wrap limit register,
// classifies the code and forms one job per character; uses otgw_pkg
`default_nettype none

module otgw_front
  import otgw_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [6:0] cfg_wdata_i,
  input  wire otgw_in_t   in_item_i,
  input  wire logic       in_take_i,
  output      otgw_job_t  job_o
);

  logic [6:0] wrap_limit_q;
  logic [7:0] col_q, col_d;
  logic [2:0] page_q, page_d;

  logic [7:0] cur_col;
  logic [2:0] cur_page;
  logic       wrap;
  logic       bad;
  logic [7:0] glyph_full;

  always_comb begin
    cur_col    = in_item_i.new_text ? {1'b0, in_item_i.start_column} : col_q;
    cur_page   = in_item_i.new_text ? in_item_i.start_page : page_q;
    wrap       = cur_col > {1'b0, wrap_limit_q};
    bad        = (in_item_i.char_code < 8'(FontFirst)) ||
                 (in_item_i.char_code >= 8'(FontFirst + FontCount));
    glyph_full = in_item_i.char_code - 8'(FontFirst);

    job_o.bad    = bad;
    job_o.glyph  = bad ? 7'd0 : glyph_full[6:0];
    job_o.page   = wrap ? cur_page + 3'd1 : cur_page;
    job_o.column = wrap ? 7'd0 : cur_col[6:0];

    col_d  = {1'b0, job_o.column} + GlyphAdvance;
    page_d = job_o.page;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wrap_limit_q <= WrapLimitReset;
      col_q        <= 8'd0;
      page_q       <= 3'd0;
    end else begin
      if (cfg_we_i) begin
        wrap_limit_q <= cfg_wdata_i;
      end
      if (in_take_i) begin
        col_q  <= col_d;
        page_q <= page_d;
      end
    end
  end

endmodule

`default_nettype wire

### hdl/otgw_job_fifo.sv
// short job queue between the front end and the byte sequencer
// uses otgw_pkg
`default_nettype none

module otgw_job_fifo
  import otgw_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      wr_en_i,
  input  wire otgw_job_t wr_job_i,
  output      logic      full_o,
  input  wire logic      rd_en_i,
  output      otgw_job_t rd_job_o,
  output      logic      empty_o
);

  `include "oled_text_glyph_writer_defines.svh"

  otgw_job_t            mem_q [JobDepth];
  logic [JobPtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [JobCntW-1:0]   count_q, count_d;
  logic                 do_wr, do_rd;

  assign full_o   = count_q == JobCntW'(JobDepth);
  assign empty_o  = count_q == '0;
  assign do_wr    = wr_en_i && !full_o;
  assign do_rd    = rd_en_i && !empty_o;
  assign rd_job_o = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (do_wr && !do_rd) begin
      count_d = count_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == JobPtrW'(JobDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == JobPtrW'(JobDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
    end
  end

  `OTGW_ASSERT_SAME(a_count_bound, 1'b1, count_q <= JobCntW'(JobDepth))
  `OTGW_ASSERT_NEXT(a_write_counts, do_wr && !do_rd, !empty_o)

endmodule

`default_nettype wire

### hdl/otgw_back.sv
// back end: walks a job through its nine bytes into a result register
// uses otgw_pkg
`default_nettype none

module otgw_back
  import otgw_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire otgw_job_t job_i,
  input  wire logic      job_empty_i,
  output      logic      job_pop_o,
  output      otgw_out_t out_item_o,
  output      logic      empty,
  input  wire logic      pop
);

  `include "oled_text_glyph_writer_defines.svh"

  otgw_beat_e  beat_q, beat_d;
  otgw_out_t   out_q, out_d;
  logic        out_valid_q, out_valid_d;
  logic        load_en, advance;
  logic [47:0] row;
  logic [7:0]  glyph_byte;

  assign load_en    = !out_valid_q || pop;
  assign advance    = load_en && !job_empty_i;
  assign row        = font_row(job_i.glyph);
  assign empty      = !out_valid_q;
  assign out_item_o = out_q;

  always_comb begin
    beat_d      = beat_q;
    job_pop_o   = 1'b0;
    glyph_byte  = 8'd0;
    out_d       = out_q;
    out_valid_d = out_valid_q && !pop;

    unique case (beat_q)
      BeatGlyph0: glyph_byte = row[47:40];
      BeatGlyph1: glyph_byte = row[39:32];
      BeatGlyph2: glyph_byte = row[31:24];
      BeatGlyph3: glyph_byte = row[23:16];
      BeatGlyph4: glyph_byte = row[15:8];
      BeatGlyph5: glyph_byte = row[7:0];
      default:    glyph_byte = 8'd0;
    endcase

    if (advance) begin
      out_valid_d    = 1'b1;
      out_d.bad_char = job_i.bad;
      out_d.is_data  = 1'b1;
      out_d.last     = 1'b0;
      out_d.byte_value = job_i.bad ? 8'd0 : glyph_byte;
      unique case (beat_q)
        BeatPage: begin
          out_d.byte_value = {PageCmdHigh, job_i.page};
          out_d.is_data    = 1'b0;
          beat_d           = BeatColHi;
        end
        BeatColHi: begin
          out_d.byte_value = {ColHiCmdHigh, 1'b0, job_i.column[6:4]};
          out_d.is_data    = 1'b0;
          beat_d           = BeatColLo;
        end
        BeatColLo: begin
          out_d.byte_value = {ColLoCmdHigh, job_i.column[3:0]};
          out_d.is_data    = 1'b0;
          beat_d           = BeatGlyph0;
        end
        BeatGlyph0: beat_d = BeatGlyph1;
        BeatGlyph1: beat_d = BeatGlyph2;
        BeatGlyph2: beat_d = BeatGlyph3;
        BeatGlyph3: beat_d = BeatGlyph4;
        BeatGlyph4: beat_d = BeatGlyph5;
        BeatGlyph5: begin
          out_d.last = 1'b1;
          job_pop_o  = 1'b1;
          beat_d     = BeatPage;
        end
        default: beat_d = BeatPage;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_q      <= BeatPage;
      out_valid_q <= 1'b0;
    end else begin
      beat_q      <= beat_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  `OTGW_ASSERT_SAME(a_job_held, beat_q != BeatPage, !job_empty_i)
  `OTGW_ASSERT_NEXT(a_last_ends_job, advance && beat_q == BeatGlyph5, beat_q == BeatPage)

endmodule

`default_nettype wire

### hdl/oled_text_glyph_writer.sv
// top level of the oled text glyph writer: front end, job queue, byte sequencer
// uses otgw_pkg, otgw_front, otgw_job_fifo and otgw_back
`default_nettype none

// Each pushed character becomes nine result bytes for a page-addressed display
// controller: page command, high and low column nibble commands, then six font
// column bytes, the last marked with last. Codes outside 32..123 draw blank
// columns and set bad_char on all nine bytes. The result port emits one byte
// per cycle while the consumer keeps popping and a job is queued; the cursor
// is updated as the character is pushed and a two-entry job queue, one entry
// of which holds the character being sent, lets the input side run ahead by
// one character while bytes are still being popped.
// Write wrap_limit only while no character is in flight.

module oled_text_glyph_writer
  import otgw_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [6:0] cfg_wdata_i,
  input  wire otgw_in_t   in_item_i,
  input  wire logic       push,
  output      logic       full,
  output      otgw_out_t  out_item_o,
  output      logic       empty,
  input  wire logic       pop
);

  otgw_job_t new_job;
  otgw_job_t head_job;
  logic      in_take;
  logic      job_empty;
  logic      job_pop;

  assign in_take = push && !full;

  otgw_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_item_i   (in_item_i),
    .in_take_i   (in_take),
    .job_o       (new_job)
  );

  otgw_job_fifo u_job_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (in_take),
    .wr_job_i (new_job),
    .full_o   (full),
    .rd_en_i  (job_pop),
    .rd_job_o (head_job),
    .empty_o  (job_empty)
  );

  otgw_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (head_job),
    .job_empty_i (job_empty),
    .job_pop_o   (job_pop),
    .out_item_o  (out_item_o),
    .empty       (empty),
    .pop         (pop)
  );

endmodule

`default_nettype wire
